>>> rtl/core/llgar_pkg.sv
// Package for the damped uniaxial-anisotropy evaluator.
// Holds stream widths, register indexes and operation and component codes.
// No dependencies.
package llgar_pkg;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [1:0] OP_RESIDUAL    = 2'd0;
  localparam logic [1:0] OP_DIAG_JAC    = 2'd1;
  localparam logic [1:0] OP_OFFDIAG_JAC = 2'd2;

  localparam logic [1:0] CMP_X    = 2'd0;
  localparam logic [1:0] CMP_Y    = 2'd1;
  localparam logic [1:0] CMP_Z    = 2'd2;
  localparam logic [1:0] CMP_NONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_COMPONENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANISO_K   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z    = 3'd5;

  localparam logic [OUT_TDATA_W-1:0] SAT_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_TDATA_W-1:0] SAT_MIN = 48'h8000_0000_0000;

endpackage

>>> rtl/core/llg_anisotropy_residual.sv
// Damped uniaxial-anisotropy residual and Jacobian, thirteen-stage pipeline.
// Depends on llgar_pkg.
//
//   channel  | ports                        | payload
//   ---------+------------------------------+------------------------------------------
//   in       | in_tvalid/in_tready/in_tdata | operation, wrt_component, mag xyz, test, shape
//   out      | out_tvalid/out_tready/...    | value in tdata, saturated in tuser
//   cfg      | cfg_we/cfg_index/cfg_wdata   | component, damping, Ku, axis xyz
//
// One word per cycle while out_tready is not held low.
// Each stage holds only while the stage after it is full and held.
// Reset (synchronous, rst_n low) empties all stages and loads register defaults.
module llg_anisotropy_residual
  import llgar_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // operation[1:0], wrt_component[3:2], mag_x[19:4], mag_y[35:20], mag_z[51:36],
  // test_value[67:52], shape_value[83:68], zero fill[87:84]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // value[47:0]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // saturated[0]
  output logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int NS = 13;
  localparam logic [85:0] RND_CORE     = 86'd1 << 37;
  localparam logic [85:0] RND_CORE_NEG = (86'd1 << 37) + 86'd1;
  localparam logic [97:0] RND_V        = 98'd1 << 31;
  localparam logic [96:0] RND_RES      = 97'd1 << 28;
  localparam logic [96:0] RND_JAC      = 97'd1 << 42;

  logic [1:0]         component_r;
  logic [15:0]        damping_r;
  logic signed [31:0] aniso_k_r;
  logic signed [15:0] axis_x_r;
  logic signed [15:0] axis_y_r;
  logic signed [15:0] axis_z_r;
  logic signed [48:0] kk_r;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] en;

  logic [1:0]         op_in;
  logic [1:0]         wrt_in;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [15:0] mag_z;
  logic signed [15:0] test_v;
  logic signed [15:0] shape_v;
  logic               zero_nxt;
  logic               jac_nxt;
  logic [1:0]         k_nxt;
  logic signed [15:0] nk_nxt;

  // stage 1
  logic               s1_zero_r, s1_jac_r;
  logic [1:0]         s1_k_r;
  logic signed [15:0] s1_nk_r;
  logic signed [31:0] s1_s_r;
  logic signed [31:0] s1_mxnx_r, s1_myny_r, s1_mznz_r;
  logic signed [31:0] s1_mxmy_r, s1_mxmx_r, s1_mymy_r, s1_mzmz_r, s1_mxmz_r, s1_mymz_r;
  logic signed [31:0] s1_mxny_r, s1_mynx_r, s1_mznx_r, s1_mxnz_r, s1_mzny_r, s1_mynz_r;
  // stage 2
  logic signed [33:0] d_nxt, a_nxt, qx_nxt, qy_nxt, qz_nxt;
  logic signed [34:0] gk_nxt;
  logic               s2_zero_r, s2_jac_r;
  logic signed [31:0] s2_s_r;
  logic signed [33:0] s2_d_r, s2_a_r, s2_qx_r, s2_qy_r, s2_qz_r;
  logic signed [34:0] s2_gk_r;
  // stage 3
  logic               s3_zero_r, s3_jac_r;
  logic signed [31:0] s3_s_r;
  logic signed [33:0] s3_a_r;
  logic signed [49:0] s3_pnx_r, s3_pny_r, s3_pnz_r;
  logic signed [52:0] s3_dgl_r;
  logic signed [50:0] s3_dgh_r;
  // stage 4
  logic               s4_zero_r, s4_jac_r;
  logic signed [31:0] s4_s_r;
  logic signed [33:0] s4_a_r;
  logic signed [51:0] s4_p_r;
  logic signed [69:0] s4_dg_r;
  // stage 5
  logic               s5_zero_r, s5_jac_r;
  logic signed [31:0] s5_s_r;
  logic signed [58:0] s5_apl_r;
  logic signed [61:0] s5_aph_r;
  logic signed [69:0] s5_dg_r;
  // stage 6
  logic               s6_zero_r, s6_jac_r;
  logic signed [31:0] s6_s_r;
  logic signed [85:0] s6_core_r;
  // stage 7
  logic [85:0]        core_x, core_sum;
  logic               s7_zero_r, s7_jac_r;
  logic signed [31:0] s7_s_r;
  logic signed [47:0] s7_c32_r;
  // stage 8
  logic               s8_zero_r, s8_jac_r;
  logic signed [31:0] s8_s_r;
  logic [47:0]        s8_ll_r;
  logic signed [49:0] s8_lh_r;
  logic signed [48:0] s8_hl_r, s8_hh_r;
  // stage 9
  logic               s9_zero_r, s9_jac_r;
  logic signed [31:0] s9_s_r;
  logic signed [50:0] s9_mid_r;
  logic signed [96:0] s9_hhll_r;
  // stage 10
  logic [97:0]        v_sum;
  logic               s10_zero_r, s10_jac_r;
  logic signed [31:0] s10_s_r;
  logic signed [63:0] s10_v_r;
  // stage 11
  logic               s11_zero_r, s11_jac_r;
  logic signed [64:0] s11_wl_r;
  logic signed [63:0] s11_wh_r;
  // stage 12
  logic [96:0]        w_sum;
  logic signed [66:0] wr_nxt;
  logic               s12_zero_r;
  logic signed [66:0] s12_wr_r;
  // stage 13
  logic [19:0]        wr_hi;
  logic               sat_nxt;
  logic [47:0]        val_nxt;
  logic [47:0]        out_data_r;
  logic               out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      component_r <= CMP_X;
      damping_r   <= '0;
      aniso_k_r   <= '0;
      axis_x_r    <= '0;
      axis_y_r    <= '0;
      axis_z_r    <= 16'sd16384;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COMPONENT: component_r <= cfg_wdata[1:0];
        REG_DAMPING:   damping_r   <= cfg_wdata[15:0];
        REG_ANISO_K:   aniso_k_r   <= cfg_wdata;
        REG_AXIS_X:    axis_x_r    <= cfg_wdata[15:0];
        REG_AXIS_Y:    axis_y_r    <= cfg_wdata[15:0];
        REG_AXIS_Z:    axis_z_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    kk_r <= $signed({1'b0, damping_r}) * aniso_k_r;
  end

  always_comb begin
    en[NS-1] = ~vld_r[NS-1] | out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = ~vld_r[i] | en[i+1];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  assign op_in   = in_tdata[1:0];
  assign wrt_in  = in_tdata[3:2];
  assign mag_x   = in_tdata[19:4];
  assign mag_y   = in_tdata[35:20];
  assign mag_z   = in_tdata[51:36];
  assign test_v  = in_tdata[67:52];
  assign shape_v = in_tdata[83:68];

  always_comb begin
    zero_nxt = (component_r == CMP_NONE)
            || (op_in != OP_RESIDUAL && op_in != OP_DIAG_JAC && op_in != OP_OFFDIAG_JAC)
            || (op_in == OP_OFFDIAG_JAC && (wrt_in == CMP_NONE || wrt_in == component_r));
    jac_nxt  = (op_in != OP_RESIDUAL);
    k_nxt    = (op_in == OP_DIAG_JAC) ? component_r : wrt_in;
    unique case (k_nxt)
      CMP_X:   nk_nxt = axis_x_r;
      CMP_Y:   nk_nxt = axis_y_r;
      CMP_Z:   nk_nxt = axis_z_r;
      default: nk_nxt = '0;
    endcase
  end

  always_comb begin
    d_nxt = 34'(s1_mxnx_r) + 34'(s1_myny_r) + 34'(s1_mznz_r);
    unique case (component_r)
      CMP_X: begin
        qx_nxt = -(34'(s1_mymy_r) + 34'(s1_mzmz_r));
        qy_nxt = 34'(s1_mxmy_r);
        qz_nxt = 34'(s1_mxmz_r);
      end
      CMP_Y: begin
        qx_nxt = -34'(s1_mxmy_r);
        qy_nxt = 34'(s1_mxmx_r) + 34'(s1_mzmz_r);
        qz_nxt = -34'(s1_mymz_r);
      end
      default: begin
        qx_nxt = 34'(s1_mxmz_r);
        qy_nxt = 34'(s1_mymz_r);
        qz_nxt = -(34'(s1_mxmx_r) + 34'(s1_mymy_r));
      end
    endcase
    gk_nxt = '0;
    unique case (component_r)
      CMP_X: begin
        unique case (s1_k_r)
          CMP_X:   gk_nxt = 35'(s1_myny_r) + 35'(s1_mznz_r);
          CMP_Y:   gk_nxt = 35'(s1_mxny_r) - (35'(s1_mynx_r) <<< 1);
          CMP_Z:   gk_nxt = 35'(s1_mxnz_r) - (35'(s1_mznx_r) <<< 1);
          default: gk_nxt = '0;
        endcase
      end
      CMP_Y: begin
        unique case (s1_k_r)
          CMP_X:   gk_nxt = (35'(s1_mxny_r) <<< 1) - 35'(s1_mynx_r);
          CMP_Y:   gk_nxt = -(35'(s1_mxnx_r) + 35'(s1_mznz_r));
          CMP_Z:   gk_nxt = (35'(s1_mzny_r) <<< 1) - 35'(s1_mynz_r);
          default: gk_nxt = '0;
        endcase
      end
      default: begin
        unique case (s1_k_r)
          CMP_X:   gk_nxt = 35'(s1_mznx_r) - (35'(s1_mxnz_r) <<< 1);
          CMP_Y:   gk_nxt = 35'(s1_mzny_r) - (35'(s1_mynz_r) <<< 1);
          CMP_Z:   gk_nxt = 35'(s1_mxnx_r) + 35'(s1_myny_r);
          default: gk_nxt = '0;
        endcase
      end
    endcase
    if (!s1_jac_r) begin
      gk_nxt = '0;
    end
    a_nxt = s1_jac_r ? 34'($signed({s1_nk_r, 14'b0})) : d_nxt;
  end

  always_comb begin
    core_x   = (component_r == CMP_Y) ? ~s6_core_r : s6_core_r;
    core_sum = core_x + ((component_r == CMP_Y) ? RND_CORE_NEG : RND_CORE);
    v_sum    = 98'(s9_hhll_r) + (98'(s9_mid_r) << 24) + RND_V;
    w_sum    = (97'(s11_wh_r) << 32) + 97'(s11_wl_r) + (s11_jac_r ? RND_JAC : RND_RES);
    wr_nxt   = s11_jac_r ? 67'($signed(w_sum[96:43])) : $signed(w_sum[95:29]);
    wr_hi    = s12_wr_r[66:47];
    sat_nxt  = !((&wr_hi) || (~|wr_hi));
    if (s12_zero_r) begin
      val_nxt = '0;
      sat_nxt = 1'b0;
    end else if (sat_nxt) begin
      val_nxt = s12_wr_r[66] ? SAT_MIN : SAT_MAX;
    end else begin
      val_nxt = s12_wr_r[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_zero_r <= zero_nxt;
      s1_jac_r  <= jac_nxt;
      s1_k_r    <= k_nxt;
      s1_nk_r   <= nk_nxt;
      s1_s_r    <= jac_nxt ? test_v * shape_v : 32'(test_v);
      s1_mxnx_r <= mag_x * axis_x_r;
      s1_myny_r <= mag_y * axis_y_r;
      s1_mznz_r <= mag_z * axis_z_r;
      s1_mxmy_r <= mag_x * mag_y;
      s1_mxmx_r <= mag_x * mag_x;
      s1_mymy_r <= mag_y * mag_y;
      s1_mzmz_r <= mag_z * mag_z;
      s1_mxmz_r <= mag_x * mag_z;
      s1_mymz_r <= mag_y * mag_z;
      s1_mxny_r <= mag_x * axis_y_r;
      s1_mynx_r <= mag_y * axis_x_r;
      s1_mznx_r <= mag_z * axis_x_r;
      s1_mxnz_r <= mag_x * axis_z_r;
      s1_mzny_r <= mag_z * axis_y_r;
      s1_mynz_r <= mag_y * axis_z_r;
    end
    if (en[1]) begin
      s2_zero_r <= s1_zero_r;
      s2_jac_r  <= s1_jac_r;
      s2_s_r    <= s1_s_r;
      s2_d_r    <= d_nxt;
      s2_a_r    <= a_nxt;
      s2_qx_r   <= qx_nxt;
      s2_qy_r   <= qy_nxt;
      s2_qz_r   <= qz_nxt;
      s2_gk_r   <= gk_nxt;
    end
    if (en[2]) begin
      s3_zero_r <= s2_zero_r;
      s3_jac_r  <= s2_jac_r;
      s3_s_r    <= s2_s_r;
      s3_a_r    <= s2_a_r;
      s3_pnx_r  <= axis_x_r * s2_qx_r;
      s3_pny_r  <= axis_y_r * s2_qy_r;
      s3_pnz_r  <= axis_z_r * s2_qz_r;
      s3_dgl_r  <= s2_d_r * $signed({1'b0, s2_gk_r[17:0]});
      s3_dgh_r  <= s2_d_r * $signed(s2_gk_r[34:18]);
    end
    if (en[3]) begin
      s4_zero_r <= s3_zero_r;
      s4_jac_r  <= s3_jac_r;
      s4_s_r    <= s3_s_r;
      s4_a_r    <= s3_a_r;
      s4_p_r    <= 52'(s3_pnx_r) + 52'(s3_pny_r) + 52'(s3_pnz_r);
      s4_dg_r   <= (70'(s3_dgh_r) <<< 18) + 70'(s3_dgl_r);
    end
    if (en[4]) begin
      s5_zero_r <= s4_zero_r;
      s5_jac_r  <= s4_jac_r;
      s5_s_r    <= s4_s_r;
      s5_dg_r   <= s4_dg_r;
      s5_apl_r  <= s4_a_r * $signed({1'b0, s4_p_r[23:0]});
      s5_aph_r  <= s4_a_r * $signed(s4_p_r[51:24]);
    end
    if (en[5]) begin
      s6_zero_r <= s5_zero_r;
      s6_jac_r  <= s5_jac_r;
      s6_s_r    <= s5_s_r;
      s6_core_r <= (86'(s5_aph_r) <<< 24) + 86'(s5_apl_r) + (86'(s5_dg_r) <<< 14);
    end
    if (en[6]) begin
      s7_zero_r <= s6_zero_r;
      s7_jac_r  <= s6_jac_r;
      s7_s_r    <= s6_s_r;
      s7_c32_r  <= core_sum[85:38];
    end
    if (en[7]) begin
      s8_zero_r <= s7_zero_r;
      s8_jac_r  <= s7_jac_r;
      s8_s_r    <= s7_s_r;
      s8_ll_r   <= s7_c32_r[23:0] * kk_r[23:0];
      s8_lh_r   <= $signed({1'b0, s7_c32_r[23:0]}) * $signed(kk_r[48:24]);
      s8_hl_r   <= $signed(s7_c32_r[47:24]) * $signed({1'b0, kk_r[23:0]});
      s8_hh_r   <= $signed(s7_c32_r[47:24]) * $signed(kk_r[48:24]);
    end
    if (en[8]) begin
      s9_zero_r <= s8_zero_r;
      s9_jac_r  <= s8_jac_r;
      s9_s_r    <= s8_s_r;
      s9_mid_r  <= 51'(s8_lh_r) + 51'(s8_hl_r);
      s9_hhll_r <= {s8_hh_r, s8_ll_r};
    end
    if (en[9]) begin
      s10_zero_r <= s9_zero_r;
      s10_jac_r  <= s9_jac_r;
      s10_s_r    <= s9_s_r;
      s10_v_r    <= v_sum[95:32];
    end
    if (en[10]) begin
      s11_zero_r <= s10_zero_r;
      s11_jac_r  <= s10_jac_r;
      s11_wl_r   <= $signed({1'b0, s10_v_r[31:0]}) * s10_s_r;
      s11_wh_r   <= $signed(s10_v_r[63:32]) * s10_s_r;
    end
    if (en[11]) begin
      s12_zero_r <= s11_zero_r;
      s12_wr_r   <= wr_nxt;
    end
    if (en[12]) begin
      out_data_r <= val_nxt;
      out_sat_r  <= sat_nxt;
    end
  end

endmodule

>>> rtl/core/llgar_checker.sv
// Port-level checks for llg_anisotropy_residual, bound to the top level.
// Depends on llgar_pkg.
module llgar_checker
  import llgar_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == SAT_MAX || out_tdata == SAT_MIN)
    else $error("saturated word not at a range limit");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input held while output side free");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

endmodule

bind llg_anisotropy_residual llgar_checker u_llgar_checker (.*);
